/* sv/sha1sh_pkg.sv */
// sha1sh_pkg: shared types and constants for the SHA-1 stream hasher.
// No dependencies.
package sha1sh_pkg;
    localparam logic [31:0] C_H0 = 32'h67452301;
    localparam logic [31:0] C_H1 = 32'hefcdab89;
    localparam logic [31:0] C_H2 = 32'h98badcfe;
    localparam logic [31:0] C_H3 = 32'h10325476;
    localparam logic [31:0] C_H4 = 32'hc3d2e1f0;
    localparam logic [31:0] C_K0 = 32'h5a827999;
    localparam logic [31:0] C_K1 = 32'h6ed9eba1;
    localparam logic [31:0] C_K2 = 32'h8f1bbcdc;
    localparam logic [31:0] C_K3 = 32'hca62c1d6;
    localparam logic [7:0]  C_PAD_BYTE = 8'h80;
    localparam logic        C_OP_ABSORB = 1'b0;
    localparam logic        C_OP_FINISH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Front-to-back command: op flag (0 = absorb byte, 1 = finish) and data byte.
    typedef t_in_item t_cmd;
endpackage

/* sv/sha1sh_if.sv */
// sha1sh_in_if / sha1sh_out_if: valid/ready channels for the hasher.
// Depends on sha1sh_pkg.
interface sha1sh_in_if;
    import sha1sh_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha1sh_out_if;
    import sha1sh_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/sha1sh_front.sv */
// sha1sh_front: accepts input items into a two-entry command queue.
// Depends on sha1sh_pkg.
module sha1sh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha1sh_pkg::t_cmd    i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output sha1sh_pkg::t_cmd    o_cmd
);
    import sha1sh_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
        end
        if (w_push) r_q[r_wr] <= i_cmd;
    end
endmodule

/* sv/sha1sh_back.sv */
// sha1sh_back: byte buffer, padding sequencer, one-round-per-cycle SHA-1
// core and digest output register. Depends on sha1sh_pkg.
module sha1sh_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sha1sh_pkg::t_cmd     i_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sha1sh_pkg::t_out_item o_item
);
    import sha1sh_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state       r_state;
    logic [31:0]  r_h [5];
    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [60:0]  r_count;
    logic [63:0]  r_bits;
    logic [5:0]   r_pos;
    logic [6:0]   r_round;
    logic         r_fin;      // current message is finishing
    logic         r_last_blk; // the block being padded holds the length
    logic [2:0]   r_oidx;

    // Byte buffer kept as 16 words; bytes land by shifting into the word.
    logic [3:0]   w_slot;
    logic [31:0]  w_x, w_wt, w_f, w_k, w_t;
    logic [7:0]   w_pad_byte;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item.digest_word = r_h[r_oidx];
    assign o_item.word_index  = r_oidx;
    assign o_item.last_word   = (r_oidx == 3'd4);

    assign w_slot = r_round[3:0];
    assign w_x = r_w[w_slot + 4'd13] ^ r_w[w_slot + 4'd8] ^ r_w[w_slot + 4'd2]
                 ^ r_w[w_slot];
    assign w_wt = (r_round < 7'd16) ? r_w[w_slot] : {w_x[30:0], w_x[31]};

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = C_K0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = C_K1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = C_K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = C_K3;
        end
        w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_wt + w_k;
    end

    // Padding byte for position r_pos: zeros, then the length when final.
    always_comb begin
        w_pad_byte = 8'h00;
        if (r_last_blk && r_pos >= 6'd56) begin
            w_pad_byte = r_bits[8'(6'd63 - r_pos) * 8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_round <= '0;
            r_fin   <= 1'b0;
            r_oidx  <= '0;
            r_h[0] <= C_H0; r_h[1] <= C_H1; r_h[2] <= C_H2;
            r_h[3] <= C_H3; r_h[4] <= C_H4;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd.op == C_OP_ABSORB) begin
                            r_w[r_pos[5:2]] <= {r_w[r_pos[5:2]][23:0], i_cmd.data_byte};
                            r_count <= r_count + 61'd1;
                            r_pos   <= r_pos + 6'd1;
                            r_fin   <= 1'b0;
                            if (r_pos == 6'd63) r_state <= S_LOAD;
                        end else begin
                            r_w[r_pos[5:2]] <= {r_w[r_pos[5:2]][23:0], C_PAD_BYTE};
                            r_bits     <= {r_count, 3'b000};
                            r_fin      <= 1'b1;
                            r_last_blk <= (r_pos < 6'd56);
                            r_pos      <= r_pos + 6'd1;
                            r_state    <= (r_pos == 6'd63) ? S_LOAD : S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_w[r_pos[5:2]] <= {r_w[r_pos[5:2]][23:0], w_pad_byte};
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (r_round >= 7'd16) r_w[w_slot] <= w_wt;
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a;
                    r_a <= w_t;
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'd79) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_round <= '0;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (!r_last_blk) begin
                        r_last_blk <= 1'b1;
                        r_state    <= S_PAD;
                    end else begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd4) begin
                            r_h[0] <= C_H0; r_h[1] <= C_H1; r_h[2] <= C_H2;
                            r_h[3] <= C_H3; r_h[4] <= C_H4;
                            r_count <= '0;
                            r_pos   <= '0;
                            r_fin   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* sv/sha1_stream_hasher_unit.sv */
// sha1_stream_hasher_unit: top level of the SHA-1 stream hasher.
// Depends on sha1sh_pkg, sha1sh_if, sha1sh_front, sha1sh_back.
//
// Feed message bytes as absorb items (op 0) and close a message with a finish
// item (op 1); the unit then returns five 32-bit digest words, index 0 first,
// last_word set on index 4, and starts over on the SHA-1 initial values. An
// absorb item is taken in the back end's idle state, and every 64th byte adds
// a compression (load, 80 rounds at one round per cycle, and the chaining
// add). A finish item pads the rest of the block one byte per cycle and runs
// one or two compressions, then holds each digest word until it is taken. A
// two-entry queue in front lets input items be taken while the core is busy.
module sha1_stream_hasher_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1sh_in_if.sink     i_in,
    sha1sh_out_if.source  o_out
);
    import sha1sh_pkg::*;

    logic q_valid, q_ready;
    t_cmd q_cmd;

    sha1sh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_cmd   (i_in.payload),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    sha1sh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cmd   (q_cmd),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.payload)
    );
endmodule
